[rtl/utf8d_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CP_WIDTH = 31;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_ERR  = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   // One input word as held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } in_word_type;

   // One result word, without the character count.
   typedef struct packed {
      kind_type              kind;
      logic [CP_WIDTH-1:0]   code_point;
      logic                  last;
   } rsp_word_type;

   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD_BAD   = 8'hFE;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;

endpackage

[rtl/utf8d_in_stage.sv]
// ---------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one byte word until the decode core consumes it.
// ---------------------------------------------------------------------------
module utf8d_in_stage
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        consume,
   output in_word_type word
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       accept;

   // The register can take a new word when empty or being emptied this cycle.
   assign req_stall = valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data_byte;
         last_in  = req_last_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign word.valid = valid_ff;
   assign word.data  = data_ff;
   assign word.last  = last_ff;

endmodule

[rtl/utf8d_core.sv]
// ---------------------------------------------------------------------------
// UTF-8 decode core
// Sequence state, code point accumulation and result selection per byte.
// ---------------------------------------------------------------------------
module utf8d_core
   import utf8d_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   input  in_word_type            word,
   input  logic                   go,
   output logic                   consume,
   output logic                   emit,
   output rsp_word_type           result,
   output logic [COUNT_WIDTH-1:0] count
);

   logic [2:0]             remain_ff, remain_in;
   logic [CP_WIDTH-1:0]    acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   disc_ff, disc_in;
   logic                   endp_ff, endp_in;

   logic [7:0]             b;
   logic                   lb;
   logic [CP_WIDTH-1:0]    acc_next;
   logic [2:0]             remain_dec;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [2:0]             lead_len;
   logic [7:0]             lead_mask;

   assign b          = word.data;
   assign lb         = word.last;
   assign acc_next   = {acc_ff[CP_WIDTH-7:0], b[5:0]};
   assign remain_dec = remain_ff - 3'd1;
   assign cnt_inc    = (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      lead_len  = 3'd0;
      lead_mask = 8'h00;
      case (b) inside
         [8'hC2:8'hDF]: begin lead_len = 3'd2; lead_mask = 8'h1F; end
         [8'hE0:8'hEF]: begin lead_len = 3'd3; lead_mask = 8'h0F; end
         [8'hF0:8'hF7]: begin lead_len = 3'd4; lead_mask = 8'h07; end
         [8'hF8:8'hFB]: begin lead_len = 3'd5; lead_mask = 8'h03; end
         [8'hFC:8'hFD]: begin lead_len = 3'd6; lead_mask = 8'h01; end
         default:       begin lead_len = 3'd0; lead_mask = 8'h00; end
      endcase
   end

   always_comb begin
      remain_in = remain_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      disc_in   = disc_ff;
      endp_in   = endp_ff;
      consume   = 1'b0;
      emit      = 1'b0;
      result.kind       = KIND_CHAR;
      result.code_point = '0;
      result.last       = 1'b1;
      count             = cnt_ff;

      if (endp_ff) begin
         // The byte before completed a character and ended the string.
         if (go) begin
            emit        = 1'b1;
            result.kind = KIND_END;
            remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = 1'b0;
            endp_in   = 1'b0;
         end
      end else if (word.valid && go) begin
         consume = 1'b1;
         if (disc_ff) begin
            if (b == 8'h00 || lb) begin
               remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = 1'b0;
            end
         end else if (b == 8'h00) begin
            emit        = 1'b1;
            result.kind = (remain_ff == 3'd0) ? KIND_END : KIND_ERR;
            remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = 1'b0;
         end else if (remain_ff == 3'd0) begin
            if (!b[7]) begin
               emit              = 1'b1;
               result.code_point = {{(CP_WIDTH-8){1'b0}}, b};
               result.last       = !lb;
               count             = cnt_inc;
               cnt_in            = cnt_inc;
               endp_in           = lb;
            end else if (b < LEAD_MIN || b >= LEAD_BAD || lb) begin
               emit        = 1'b1;
               result.kind = KIND_ERR;
               remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = !lb;
            end else begin
               acc_in    = {{(CP_WIDTH-8){1'b0}}, b & lead_mask};
               remain_in = lead_len - 3'd1;
            end
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            emit        = 1'b1;
            result.kind = KIND_ERR;
            remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = !lb;
         end else if (remain_dec == 3'd0) begin
            emit              = 1'b1;
            result.code_point = acc_next;
            result.last       = !lb;
            count             = cnt_inc;
            cnt_in            = cnt_inc;
            remain_in         = '0;
            acc_in            = '0;
            endp_in           = lb;
         end else if (lb) begin
            // The buffer ends with the sequence still open.
            emit        = 1'b1;
            result.kind = KIND_ERR;
            remain_in = '0; acc_in = '0; cnt_in = '0; disc_in = 1'b0;
         end else begin
            acc_in    = acc_next;
            remain_in = remain_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         disc_ff   <= 1'b0;
         endp_ff   <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         disc_ff   <= disc_in;
         endp_ff   <= endp_in;
      end
   end

endmodule

[rtl/utf8d_out_stage.sv]
// ---------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module utf8d_out_stage
   import utf8d_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   emit,
   input  rsp_word_type           result,
   input  logic [COUNT_WIDTH-1:0] count,
   output logic                   go,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [CP_WIDTH-1:0]    rsp_code_point,
   output logic [COUNT_WIDTH-1:0] rsp_char_count,
   output logic                   rsp_last
);

   logic                   valid_ff, valid_in;
   rsp_word_type           word_ff, word_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // A new result may be loaded when the register is empty or being read.
   assign go = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      count_in = count_ff;
      if (go) begin
         valid_in = emit;
         if (emit) begin
            word_in  = result;
            count_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff  <= word_in;
      count_ff <= count_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = word_ff.kind;
   assign rsp_code_point = word_ff.code_point;
   assign rsp_char_count = count_ff;
   assign rsp_last       = word_ff.last;

endmodule

[rtl/utf8_stream_decoder.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream of one- to six-byte UTF-8 sequences into code points.
//
// Input channel (req_): one byte word per handshake, with req_last_byte
// marking the final byte of a bounded buffer. Result channel (rsp_): one
// word per decoded character, error or string end, with the running count.
// A byte accepted into the input register is decoded from there; its first
// result is loaded into the result register when that is empty or being
// read, and so reaches the rsp_ ports. One byte per cycle is sustained while
// the receiver takes one result per cycle. A byte that completes a character
// and ends the string gives two results; the end word follows the character
// word; the next byte waits in the input register until the end word is loaded.
// When rsp_stall is high the result register holds, the input register
// fills, and req_stall rises until the receiver takes the pending result.
// Reset clears both registers and the decode state; words pending in them are
// dropped, none is produced, and the first byte after reset starts a new string.
// ---------------------------------------------------------------------------
module utf8_stream_decoder
   import utf8d_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [CP_WIDTH-1:0]    rsp_code_point,
   output logic [COUNT_WIDTH-1:0] rsp_char_count,
   output logic                   rsp_last
);

   in_word_type            word;
   rsp_word_type           result;
   logic [COUNT_WIDTH-1:0] count;
   logic                   consume;
   logic                   emit;
   logic                   go;

   utf8d_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .consume       (consume),
      .word          (word)
   );

   utf8d_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock   (clock),
      .reset   (reset),
      .word    (word),
      .go      (go),
      .consume (consume),
      .emit    (emit),
      .result  (result),
      .count   (count)
   );

   utf8d_out_stage #(.COUNT_WIDTH(COUNT_WIDTH)) u_out (
      .clock          (clock),
      .reset          (reset),
      .emit           (emit),
      .result         (result),
      .count          (count),
      .go             (go),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_code_point (rsp_code_point),
      .rsp_char_count (rsp_char_count),
      .rsp_last       (rsp_last)
   );

endmodule

[sim/utf8_decode_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Watches the byte and result channels of the decoder, keeps its own copy of
// the decode state, predicts the result words of every accepted byte word and
// compares each accepted result word with the oldest prediction.
// ---------------------------------------------------------------------------
module utf8_decode_checker
   import utf8d_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_kind,
   input  logic [CP_WIDTH-1:0]    rsp_code_point,
   input  logic [COUNT_WIDTH-1:0] rsp_char_count,
   input  logic                   rsp_last,
   output int                     mismatch_count,
   output int                     words_outstanding
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      kind_type               kind;
      logic [CP_WIDTH-1:0]    code_point;
      logic [COUNT_WIDTH-1:0] char_count;
      logic                   last;
   } result_word_type;

   result_word_type        expected_words[$];
   logic [2:0]             cont_left;
   logic [CP_WIDTH-1:0]    cp_accum;
   logic [COUNT_WIDTH-1:0] chars_decoded;
   logic                   dropping;
   int                     fail_tally = 0;

   task automatic start_string();
      cont_left     = '0;
      cp_accum      = '0;
      chars_decoded = '0;
      dropping      = 1'b0;
   endtask

   // Every word carries the count as it stands when the word is produced.
   task automatic push_word(input kind_type kind, input logic [CP_WIDTH-1:0] cp,
                            input logic last);
      result_word_type w;
      w.kind       = kind;
      w.code_point = cp;
      w.char_count = chars_decoded;
      w.last       = last;
      expected_words.push_back(w);
   endtask

   // An error ends the string; unless the byte itself ended it, the rest of
   // the string is dropped.
   task automatic flag_error(input logic ends);
      push_word(KIND_ERR, '0, 1'b1);
      start_string();
      dropping = !ends;
   endtask

   task automatic complete_char(input logic [CP_WIDTH-1:0] cp, input logic ends);
      if (chars_decoded != COUNT_MAX)
         chars_decoded++;
      push_word(KIND_CHAR, cp, !ends);
      cont_left = '0;
      cp_accum  = '0;
      if (ends) begin
         push_word(KIND_END, '0, 1'b1);
         start_string();
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic ends);
      logic [7:0] lead_mask;
      logic [2:0] seq_len;
      lead_mask = '0;
      seq_len   = '0;
      if (dropping) begin
         if (b == 8'h00 || ends)
            start_string();
      end else if (b == 8'h00) begin
         if (cont_left == 0) begin
            push_word(KIND_END, '0, 1'b1);
            start_string();
         end else begin
            flag_error(1'b1);
         end
      end else if (cont_left == 0) begin
         if (b < CONT_TAG) begin
            complete_char(CP_WIDTH'(b), ends);
         end else if (b < LEAD_MIN || b >= LEAD_BAD) begin
            flag_error(ends);
         end else if (ends) begin
            flag_error(1'b1);
         end else begin
            if (b < 8'hE0) begin
               seq_len = 3'd2; lead_mask = 8'h1F;
            end else if (b < 8'hF0) begin
               seq_len = 3'd3; lead_mask = 8'h0F;
            end else if (b < 8'hF8) begin
               seq_len = 3'd4; lead_mask = 8'h07;
            end else if (b < 8'hFC) begin
               seq_len = 3'd5; lead_mask = 8'h03;
            end else begin
               seq_len = 3'd6; lead_mask = 8'h01;
            end
            cp_accum  = CP_WIDTH'(b & lead_mask);
            cont_left = seq_len - 3'd1;
         end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
         flag_error(ends);
      end else begin
         cp_accum  = {cp_accum[CP_WIDTH-7:0], b[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 0)
            complete_char(cp_accum, ends);
         else if (ends)
            flag_error(1'b1);
      end
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         fail_tally++;
         if (fail_tally <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // A byte accepted at an edge cannot produce a result at that same edge,
   // so results are matched before the new byte is decoded.
   always @(posedge clock) begin : watch_channels
      result_word_type want;
      if (reset) begin
         expected_words.delete();
         start_string();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (expected_words.size() == 0) begin
               fail_tally++;
               if (fail_tally <= MAX_REPORTS)
                  $display("%0t: unexpected result word, expected none, actual kind %0h cp %0h",
                           $time, rsp_kind, rsp_code_point);
            end else begin
               want = expected_words.pop_front();
               report_field("kind", 32'(want.kind), 32'(rsp_kind));
               report_field("code_point", 32'(want.code_point), 32'(rsp_code_point));
               report_field("char_count", 32'(want.char_count), 32'(rsp_char_count));
               report_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            decode_byte(req_data_byte, req_last_byte);
      end
      mismatch_count    <= fail_tally;
      words_outstanding <= expected_words.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed strings and random well-formed and corrupted strings, with
// bursty input and random result stalls; the checker beside the decoder
// predicts and compares.
// ---------------------------------------------------------------------------
module testbench
   import utf8d_pkg::*;
();

   localparam int COUNT_WIDTH      = 16;
   localparam int CYCLE_LIMIT      = 1_500_000;
   localparam int RANDOM_BYTES     = 1000;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_stall     = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [1:0]             rsp_kind;
   logic [CP_WIDTH-1:0]    rsp_code_point;
   logic [COUNT_WIDTH-1:0] rsp_char_count;
   logic                   rsp_last;
   int                     mismatch_count;
   int                     words_outstanding;
   int                     cycle_count = 0;
   int                     burst_left  = 0;
   logic [8:0]             string_bytes[$];

   utf8_stream_decoder #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_code_point (rsp_code_point),
      .rsp_char_count (rsp_char_count),
      .rsp_last       (rsp_last)
   );

   utf8_decode_checker #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_code_point    (rsp_code_point),
      .rsp_char_count    (rsp_char_count),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** utf8_stream_decoder: FAILED **");
         $finish;
      end
   end

   // Offers one byte word and returns once it has been taken. Between bursts
   // the sender may drop valid for a random number of cycles.
   task automatic send_byte(input logic [7:0] value, input logic mark);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 20);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0)
         burst_left--;
   endtask

   // At least one edge passes with valid low, so a following send never
   // lowers and raises valid in the same step.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   // Appends one well-formed character of the given length with random bits.
   task automatic add_char(input int seq_len);
      logic [7:0] lead;
      case (seq_len)
         1: lead = 8'($urandom_range(8'h01, 8'h7F));
         2: lead = 8'($urandom_range(8'hC2, 8'hDF));
         3: lead = 8'($urandom_range(8'hE0, 8'hEF));
         4: lead = 8'($urandom_range(8'hF0, 8'hF7));
         5: lead = 8'($urandom_range(8'hF8, 8'hFB));
         default: lead = 8'($urandom_range(8'hFC, 8'hFD));
      endcase
      string_bytes.push_back({1'b0, lead});
      repeat (seq_len - 1) string_bytes.push_back({1'b0, 2'b10, 6'($urandom)});
   endtask

   // The receiver mixes free-running stretches, random stalls and long
   // hold-offs that back the decoder up into its input.
   initial begin : result_sink
      int seg_index;
      int seg_len;
      int stall_pct;
      seg_index = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         seg_index++;
         if (seg_index == 3 || $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else begin
            seg_len = $urandom_range(10, 200);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
            repeat (seg_len) begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   initial begin : byte_source
      int         good_bytes;
      int         pick;
      int         idx;
      bit         paused;
      logic [8:0] entry;
      good_bytes = 0;
      paused     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Largest single-byte character, then an end at a boundary.
      send_byte(8'h7F, 1'b0);
      send_byte(8'h00, 1'b0);
      // Smallest two-byte character.
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      // Largest six-byte character.
      send_byte(8'hFD, 1'b0);
      repeat (5) send_byte(8'hBF, 1'b0);
      // Marked byte that completes a character: character word, then end word.
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b1);
      // Zero byte inside a sequence.
      send_byte(8'hE0, 1'b0);
      send_byte(8'h00, 1'b0);
      // Bad lead byte; the rest is dropped until the marked byte.
      send_byte(8'hC1, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);
      // Bad continuation; a zero byte ends the dropping.
      send_byte(8'hE1, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);
      // Marked lead byte, and a marked byte that leaves a sequence open.
      send_byte(8'hF0, 1'b1);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h8F, 1'b1);
      // Highest bad lead bytes.
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFF, 1'b1);

      while (good_bytes < RANDOM_BYTES) begin
         string_bytes.delete();
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12))
               string_bytes.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
         end else begin
            repeat ($urandom_range(0, 6)) begin
               pick = $urandom_range(0, 9);
               add_char(pick < 4 ? 1 : pick < 6 ? 2 : pick < 8 ? 3 : pick == 8 ? 4
                                      : $urandom_range(5, 6));
            end
            if (string_bytes.size() > 0 && $urandom_range(0, 1) == 1) begin
               entry = string_bytes[string_bytes.size() - 1];
               entry[8] = 1'b1;
               string_bytes[string_bytes.size() - 1] = entry;
            end else begin
               string_bytes.push_back({1'($urandom_range(0, 1)), 8'h00});
            end
            if ($urandom_range(0, 5) == 0) begin
               // Break the string: a wild byte, an early mark or a lost byte.
               idx   = $urandom_range(0, string_bytes.size() - 1);
               entry = string_bytes[idx];
               case ($urandom_range(0, 2))
                  0: begin
                     entry[7:0] = 8'($urandom);
                     string_bytes[idx] = entry;
                  end
                  1: begin
                     entry[8] = 1'b1;
                     string_bytes[idx] = entry;
                  end
                  default: string_bytes.delete(idx);
               endcase
            end else begin
               good_bytes += string_bytes.size();
            end
         end
         foreach (string_bytes[i])
            send_byte(string_bytes[i][7:0], string_bytes[i][8]);
         if (!paused && good_bytes >= RANDOM_BYTES / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
      end

      send_byte(8'hC3, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("** utf8_stream_decoder: PASSED **");
      else
         $display("** utf8_stream_decoder: FAILED **");
      $finish;
   end

endmodule

[utf8_stream_decoder.f]
rtl/utf8d_pkg.sv
rtl/utf8d_in_stage.sv
rtl/utf8d_core.sv
rtl/utf8d_out_stage.sv
rtl/utf8_stream_decoder.sv
sim/utf8_decode_checker.sv
sim/testbench.sv
